[rtl/dvrt_pkg.sv]
// ---------------------------------------------------------------------------
// Distance-vector route table package
// Shared types, codes and constants for the route table core.
// ---------------------------------------------------------------------------
package dvrt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int NUM_PORTS_DEF     = 4;
  localparam int CFG_PORTS         = 4;
  localparam int CFG_AW            = 5;
  localparam logic [4:0] INF_COST  = 5'd16;

  // register index of the first interface address register
  localparam logic [2:0] REG_IFACE0 = 3'd4;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_DUMP   = 2'd2,
    OP_LOCAL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_APPLIED  = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_ERASED   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_ROUTE    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_ACT,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [3:0]  cost;
    logic [1:0]  port;
  } slot_t;

  typedef struct packed {
    logic [CFG_PORTS-1:0][3:0]  link_cost;
    logic [CFG_PORTS-1:0][31:0] iface_addr;
  } cfg_t;

endpackage

[rtl/dvrt_slot_mem.sv]
// ---------------------------------------------------------------------------
// Route slot memory
// Single-port synchronous RAM holding destination, cost and port per slot.
// ---------------------------------------------------------------------------
module dvrt_slot_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            en,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  dvrt_pkg::slot_t wdata,
  output dvrt_pkg::slot_t rdata
);
  import dvrt_pkg::*;

  slot_t mem [DEPTH];
  slot_t rdata_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dvrt_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file for link costs and interface addresses.
// ---------------------------------------------------------------------------
module dvrt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dvrt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output dvrt_pkg::cfg_t              cfg
);
  import dvrt_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx     = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready  = 1'b1;
  assign wr_en       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      if (reg_idx < REG_IFACE0) begin
        cfg_nxt.link_cost[reg_idx[1:0]] = cfg_pwdata[3:0];
      end else begin
        cfg_nxt.iface_addr[reg_idx[1:0]] = cfg_pwdata;
      end
    end
  end

  always_comb begin
    if (reg_idx < REG_IFACE0) begin
      cfg_prdata = {28'd0, cfg_r.link_cost[reg_idx[1:0]]};
    end else begin
      cfg_prdata = cfg_r.iface_addr[reg_idx[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < CFG_PORTS; p++) begin
        cfg_r.link_cost[p]  <= 4'd1;
        cfg_r.iface_addr[p] <= 32'd0;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/distance_vector_route_table_core.sv]
// ---------------------------------------------------------------------------
// Distance-vector route table core
// Host route table kept by the distance-vector rule, one request at a time.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser carries the operation (update, query,
//           dump, add local); in_tdata the destination, advertised metric,
//           receive port and sender address.
//   out_* : result stream. in_tdata-style packing of status, route address,
//           cost and port; out_tlast marks the final result of a request.
//   cfg_* : APB-style port, link cost per port at 0x00..0x0C and own
//           interface address per port at 0x10..0x1C. Write only when idle.
// Sequence:
//   Update, query and add local read every slot once, since the slot
//   memory has one port; a flush state then drains the read pipeline
//   and the act state writes back and presents the result, waiting
//   while the output register is still held. Dump skips empty slots
//   and reads and emits each valid slot over the same single port.
// Reset clears the valid mark of every slot at once; no clearing pass.
// A stalled receiver holds the output register; the next request is still
// taken while a result waits, and the core pauses only when it must emit.
// ---------------------------------------------------------------------------
module distance_vector_route_table_core #(
  parameter int TABLE_ENTRIES = dvrt_pkg::TABLE_ENTRIES_DEF,
  parameter int NUM_PORTS     = dvrt_pkg::NUM_PORTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [31:0] dest_addr, [63:32] adv_metric, [65:64] rx_port,
  // [97:66] sender_addr, [103:98] zero
  input  logic [103:0]                in_tdata,
  // [1:0] operation
  input  logic [1:0]                  in_tuser,
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] status, [34:3] route_addr, [39:35] route_cost,
  // [41:40] route_port, [47:42] zero
  output logic [47:0]                 out_tdata,
  output logic                        out_tlast,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dvrt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dvrt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  cfg_t cfg;

  dvrt_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // slot memory port
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  slot_t         mem_wdata;
  slot_t         mem_rdata;

  dvrt_slot_mem #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // control and scan state
  state_t                   state_r, state_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic [AW-1:0]            hit_idx_r, hit_idx_nxt;
  slot_t                    hit_slot_r, hit_slot_nxt;
  logic                     free_r, free_nxt;
  logic [AW-1:0]            free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // held request
  op_t         op_r, op_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic [31:0] adv_r, adv_nxt;
  logic [1:0]  port_r, port_nxt;
  logic [31:0] sender_r, sender_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [4:0]  out_cost_r, out_cost_nxt;
  logic [1:0]  out_port_r, out_port_nxt;
  logic        out_last_r, out_last_nxt;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // request decision, evaluated in the act cycle from held fields
  logic          sender_own;
  logic          port_bad;
  logic          dest_own;
  logic [4:0]    sum5;
  logic [4:0]    metric;
  status_t       res_status;
  logic [31:0]   res_addr;
  logic [4:0]    res_cost;
  logic [1:0]    res_port;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic [3:0]    wr_cost;
  logic          clr_en;

  always_comb begin
    sender_own = 1'b0;
    for (int p = 0; p < CFG_PORTS; p++) begin
      if (p < NUM_PORTS && cfg.iface_addr[p] == sender_r) begin
        sender_own = 1'b1;
      end
    end
    port_bad = (int'(port_r) >= NUM_PORTS);
    dest_own = (dest_r == cfg.iface_addr[port_r]);
    sum5     = {1'b0, adv_r[3:0]} + {1'b0, cfg.link_cost[port_r]};
    // saturate at infinity
    metric   = (|adv_r[31:4] || sum5 > INF_COST) ? INF_COST : sum5;

    res_status = ST_IGNORED;
    res_addr   = dest_r;
    res_cost   = 5'd0;
    res_port   = port_r;
    wr_en      = 1'b0;
    wr_idx     = hit_r ? hit_idx_r : free_idx_r;
    wr_cost    = 4'd0;
    clr_en     = 1'b0;

    unique case (op_r)
      OP_UPDATE: begin
        if (sender_own || port_bad || dest_own) begin
          res_status = ST_IGNORED;
        end else begin
          res_cost = metric;
          wr_cost  = metric[3:0];
          if (metric == INF_COST) begin
            if (hit_r && hit_slot_r.port == port_r) begin
              clr_en     = 1'b1;
              res_status = ST_ERASED;
            end
          end else if (!hit_r) begin
            if (free_r) begin
              wr_en      = 1'b1;
              res_status = ST_APPLIED;
            end else begin
              res_status = ST_FULL;
            end
          end else if (hit_slot_r.port == port_r || metric[3:0] < hit_slot_r.cost) begin
            wr_en      = 1'b1;
            res_status = ST_APPLIED;
          end
        end
      end
      OP_QUERY: begin
        if (hit_r) begin
          res_status = ST_ROUTE;
          res_addr   = hit_slot_r.dest;
          res_cost   = {1'b0, hit_slot_r.cost};
          res_port   = hit_slot_r.port;
        end else begin
          res_status = ST_NOTFOUND;
          res_cost   = INF_COST;
          res_port   = 2'd0;
        end
      end
      OP_DUMP: begin
        // only reached here with an empty table
        res_status = ST_EMPTY;
        res_addr   = 32'd0;
        res_port   = 2'd0;
      end
      OP_LOCAL: begin
        if (port_bad) begin
          res_status = ST_IGNORED;
        end else if (hit_r || free_r) begin
          wr_en      = 1'b1;
          res_status = ST_APPLIED;
        end else begin
          res_status = ST_FULL;
        end
      end
      default: begin
        res_status = ST_IGNORED;
      end
    endcase
  end

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_slot_nxt   = hit_slot_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    op_nxt         = op_r;
    dest_nxt       = dest_r;
    adv_nxt        = adv_r;
    port_nxt       = port_r;
    sender_nxt     = sender_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_cost_nxt   = out_cost_r;
    out_port_nxt   = out_port_r;
    out_last_nxt   = out_last_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = idx_r;
    mem_wdata      = '{dest: dest_r, cost: wr_cost, port: port_r};
    in_tready      = (state_r == S_IDLE);

    // compare the slot read in the previous cycle
    if (cmp_vld_r && valid_r[cmp_idx_r] && mem_rdata.dest == dest_r) begin
      hit_nxt      = 1'b1;
      hit_idx_nxt  = cmp_idx_r;
      hit_slot_nxt = mem_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_t'(in_tuser);
          dest_nxt   = in_tdata[31:0];
          adv_nxt    = in_tdata[63:32];
          port_nxt   = in_tdata[65:64];
          sender_nxt = in_tdata[97:66];
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          if (op_t'(in_tuser) == OP_DUMP) begin
            state_nxt = (valid_r == '0) ? S_ACT : S_DUMP_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_en      = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        // remember the lowest free slot
        if (!valid_r[idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_FLUSH: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status;
          out_addr_nxt   = res_addr;
          out_cost_nxt   = res_cost;
          out_port_nxt   = res_port;
          out_last_nxt   = 1'b1;
          if (wr_en) begin
            mem_en            = 1'b1;
            mem_we            = 1'b1;
            mem_addr          = wr_idx;
            valid_nxt[wr_idx] = 1'b1;
          end
          if (clr_en) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        // skip empty slots; a valid one always remains ahead
        if (valid_r[idx_r]) begin
          mem_en    = 1'b1;
          state_nxt = S_DUMP_OUT;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ROUTE;
          out_addr_nxt   = mem_rdata.dest;
          out_cost_nxt   = {1'b0, mem_rdata.cost};
          out_port_nxt   = mem_rdata.port;
          out_last_nxt   = ((valid_r >> idx_r) == TABLE_ENTRIES'(1));
          if ((valid_r >> idx_r) == TABLE_ENTRIES'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_idx_r   <= free_idx_nxt;
    op_r         <= op_nxt;
    dest_r       <= dest_nxt;
    adv_r        <= adv_nxt;
    port_r       <= port_nxt;
    sender_r     <= sender_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_cost_r   <= out_cost_nxt;
    out_port_r   <= out_port_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_port_r, out_cost_r, out_addr_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule
